// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// checked during reset as well
`define ASSERT_RST_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_RST_PROP(lbl, prop)
`endif

`endif

// ----- rtl/core/qte_pkg.sv -----
package qte_pkg;

  localparam int T_W         = 36;
  localparam int P_W         = 30;
  localparam int N_W         = 58;
  localparam int ROOT_W      = 29;
  localparam int REM_W       = 31;
  localparam int ISQRT_STEPS = 29;
  localparam int DATA_W      = 45;
  localparam int M_W         = 41;
  localparam int ANG_W       = 30;
  localparam int RND_W       = 17;
  localparam int NORM_STEPS  = 7;
  localparam int TAB_LEN     = 24;

  localparam logic signed [T_W-1:0] ONE_Q28 = T_W'(268435456);
  localparam logic [N_W-1:0] ONE_Q56 = N_W'(1) << 56;
  localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(94371840);
  localparam logic signed [ANG_W-1:0] HALF_RND = ANG_W'(4096);
  localparam logic signed [15:0] ROLL_LIM  = 16'sd23040;
  localparam logic signed [14:0] PITCH_LIM = 15'sd11520;

  // atan(2^-i) in degrees * 2^20
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
    30'sd1876857, 30'sd938658, 30'sd469357, 30'sd234682, 30'sd117342,
    30'sd58671, 30'sd29335, 30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
    30'sd917, 30'sd458, 30'sd229, 30'sd115, 30'sd57, 30'sd29, 30'sd14, 30'sd7
  };

  typedef struct packed {
    logic signed [T_W-1:0] t0;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
    logic signed [T_W-1:0] t3;
    logic signed [T_W-1:0] t4;
  } terms_t;

  // binary normalization: shift amount and magnitude bound of each step
  function automatic int norm_shift(int j);
    return (j < 6) ? (32 >> j) : 1;
  endfunction

  function automatic int norm_thr(int j);
    return (j < 6) ? (40 - (32 >> j)) : 40;
  endfunction

endpackage

// ----- rtl/core/qte_terms.sv -----
module qte_terms
  import qte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               v_in,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] z,
  input  logic signed [15:0] w,
  output logic               v_out,
  output logic [N_W-1:0]     n,
  output terms_t             terms
);

  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_zz, p_wy, p_zx, p_wz, p_xy;
  terms_t t;
  logic   v1, v2;

  logic signed [T_W-1:0] t2_raw;
  logic signed [T_W-1:0] t2_sat;
  logic signed [2*P_W-1:0] sq;

  assign t2_raw = (T_W'(p_wy) - T_W'(p_zx)) <<< 1;
  assign t2_sat = (t2_raw > ONE_Q28) ? ONE_Q28 : ((t2_raw < -ONE_Q28) ? -ONE_Q28 : t2_raw);
  assign sq = (2*P_W)'($signed(t.t2[P_W-1:0])) * (2*P_W)'($signed(t.t2[P_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v1 <= v_in;
      v2 <= v1;
      v_out <= v2;
      p_wx <= 32'(w) * 32'(x);
      p_yz <= 32'(y) * 32'(z);
      p_xx <= 32'(x) * 32'(x);
      p_yy <= 32'(y) * 32'(y);
      p_zz <= 32'(z) * 32'(z);
      p_wy <= 32'(w) * 32'(y);
      p_zx <= 32'(z) * 32'(x);
      p_wz <= 32'(w) * 32'(z);
      p_xy <= 32'(x) * 32'(y);
      t.t0 <= (T_W'(p_wx) + T_W'(p_yz)) <<< 1;
      t.t1 <= ONE_Q28 - ((T_W'(p_xx) + T_W'(p_yy)) <<< 1);
      t.t2 <= t2_sat;
      t.t3 <= (T_W'(p_wz) + T_W'(p_xy)) <<< 1;
      t.t4 <= ONE_Q28 - ((T_W'(p_yy) + T_W'(p_zz)) <<< 1);
      // 1 - t2^2 in units of 2^-56
      n <= ONE_Q56 - sq[N_W-1:0];
      terms <= t;
    end
  end

endmodule

// ----- rtl/core/qte_isqrt.sv -----
module qte_isqrt
  import qte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  logic [N_W-1:0]    n_in,
  output logic              v_out,
  output logic [ROOT_W-1:0] root
);

  logic [N_W-1:0]    sq_n    [ISQRT_STEPS+1];
  logic [REM_W-1:0]  sq_rem  [ISQRT_STEPS+1];
  logic [ROOT_W-1:0] sq_root [ISQRT_STEPS+1];
  logic              sq_v    [ISQRT_STEPS+1];

  assign sq_n[0]    = n_in;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_v[0]    = v_in;

  // one result bit per stage, restoring method
  for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_step
    localparam int P = ISQRT_STEPS - 1 - j;
    logic [REM_W-1:0] rs, tr;
    logic             ge;
    assign rs = {sq_rem[j][REM_W-3:0], sq_n[j][2*P+1 -: 2]};
    assign tr = {sq_root[j], 2'b01};
    assign ge = (rs >= tr);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1]    <= sq_v[j];
        sq_n[j+1]    <= sq_n[j];
        sq_rem[j+1]  <= ge ? (rs - tr) : rs;
        sq_root[j+1] <= {sq_root[j][ROOT_W-2:0], ge};
      end
    end
  end

  assign v_out = sq_v[ISQRT_STEPS];
  assign root  = sq_root[ISQRT_STEPS];

endmodule

// ----- rtl/core/qte_atan2.sv -----
module qte_atan2
  import qte_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    v_in,
  input  logic signed [T_W-1:0]   y_in,
  input  logic signed [T_W-1:0]   x_in,
  output logic                    v_out,
  output logic signed [RND_W-1:0] ang
);

  logic signed [DATA_W-1:0] nx [NORM_STEPS+1];
  logic signed [DATA_W-1:0] ny [NORM_STEPS+1];
  logic [M_W-1:0]           nm [NORM_STEPS+1];
  logic                     nz [NORM_STEPS+1];
  logic                     nv [NORM_STEPS+1];

  logic signed [DATA_W-1:0] cx [STAGES+1];
  logic signed [DATA_W-1:0] cy [STAGES+1];
  logic signed [ANG_W-1:0]  ca [STAGES+1];
  logic                     cz [STAGES+1];
  logic                     cv [STAGES+1];

  logic signed [T_W-1:0] ax, ay;
  logic signed [ANG_W-1:0] rsum;

  assign ax = x_in[T_W-1] ? -x_in : x_in;
  assign ay = y_in[T_W-1] ? -y_in : y_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv[0] <= 1'b0;
    end else if (en) begin
      nv[0] <= v_in;
      nx[0] <= DATA_W'(x_in);
      ny[0] <= DATA_W'(y_in);
      // leading one of the or matches that of the larger magnitude
      nm[0] <= M_W'(ax) | M_W'(ay);
      nz[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int K   = norm_shift(j);
    localparam int THR = norm_thr(j);
    logic sh;
    assign sh = nm[j] < (M_W'(1) << THR);

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[j+1] <= 1'b0;
      end else if (en) begin
        nv[j+1] <= nv[j];
        nz[j+1] <= nz[j];
        nx[j+1] <= sh ? (nx[j] <<< K) : nx[j];
        ny[j+1] <= sh ? (ny[j] <<< K) : ny[j];
        nm[j+1] <= sh ? (nm[j] << K) : nm[j];
      end
    end
  end

  // fold the left half plane by a quarter turn
  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= nv[NORM_STEPS];
      cz[0] <= nz[NORM_STEPS];
      if (nx[NORM_STEPS] < 0) begin
        if (ny[NORM_STEPS] >= 0) begin
          cx[0] <= ny[NORM_STEPS];
          cy[0] <= -nx[NORM_STEPS];
          ca[0] <= DEG90;
        end else begin
          cx[0] <= -ny[NORM_STEPS];
          cy[0] <= nx[NORM_STEPS];
          ca[0] <= -DEG90;
        end
      end else begin
        cx[0] <= nx[NORM_STEPS];
        cy[0] <= ny[NORM_STEPS];
        ca[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
        cz[i+1] <= cz[i];
        if (cy[i] >= 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          ca[i+1] <= ca[i] + ATAN_TAB[i];
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          ca[i+1] <= ca[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign rsum = ca[STAGES] + HALF_RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= cv[STAGES];
      ang   <= cz[STAGES] ? '0 : RND_W'(rsum >>> 13);
    end
  end

endmodule

// ----- rtl/core/quaternion_to_euler_angles_unit.sv -----
// quaternion to roll, pitch and yaw
//
// input channel: in_valid / in_stall with quat_x, quat_y, quat_z, quat_w in
// signed q1.14. output channel: out_valid / out_stall with roll_deg,
// pitch_deg and yaw_deg in degrees, 128 steps per degree, saturated.
// a transaction happens on a rising edge with valid high and stall low.
//
// fully pipelined: one quaternion per cycle unless a stalled output holds
// the pipeline. the length is set by the pitch path: registers of products
// and sums, a square root of 1 - t^2 with one result bit per stage, then
// per angle an input register, normalization, quadrant fold, the cordic
// stages and rounding, and finally the saturating output register.
//
// reset clears all valid bits; no results are pending afterwards.
// while a result sits in the output register under out_stall, the whole
// pipeline holds and in_stall is raised; nothing is lost or repeated.
`include "assert_macros.svh"

module quaternion_to_euler_angles_unit
  import qte_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_deg,
  output logic signed [14:0] pitch_deg,
  output logic signed [15:0] yaw_deg
);

  localparam int STAGES = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;

  logic en;
  logic tm_v, sq_v;
  logic [N_W-1:0] tm_n;
  terms_t tm_terms;
  terms_t dly [ISQRT_STEPS];
  logic [ROOT_W-1:0] root;
  logic signed [T_W-1:0] c_ext;
  logic rv, pv, yv;
  logic signed [RND_W-1:0] ra, pa, ya;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  qte_terms u_terms (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v_in  (in_valid),
    .x     (quat_x),
    .y     (quat_y),
    .z     (quat_z),
    .w     (quat_w),
    .v_out (tm_v),
    .n     (tm_n),
    .terms (tm_terms)
  );

  qte_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v_in  (tm_v),
    .n_in  (tm_n),
    .v_out (sq_v),
    .root  (root)
  );

  // hold the product terms while the root is formed
  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= tm_terms;
      for (int k = 1; k < ISQRT_STEPS; k++) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  assign c_ext = $signed({{(T_W-ROOT_W){1'b0}}, root});

  qte_atan2 #(.STAGES(STAGES)) u_roll (
    .clk (clk), .rst (rst), .en (en), .v_in (sq_v),
    .y_in (dly[ISQRT_STEPS-1].t0), .x_in (dly[ISQRT_STEPS-1].t1),
    .v_out (rv), .ang (ra)
  );

  qte_atan2 #(.STAGES(STAGES)) u_pitch (
    .clk (clk), .rst (rst), .en (en), .v_in (sq_v),
    .y_in (dly[ISQRT_STEPS-1].t2), .x_in (c_ext),
    .v_out (pv), .ang (pa)
  );

  qte_atan2 #(.STAGES(STAGES)) u_yaw (
    .clk (clk), .rst (rst), .en (en), .v_in (sq_v),
    .y_in (dly[ISQRT_STEPS-1].t3), .x_in (dly[ISQRT_STEPS-1].t4),
    .v_out (yv), .ang (ya)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rv;
      if (ra > RND_W'(ROLL_LIM)) roll_deg <= ROLL_LIM;
      else if (ra < -RND_W'(ROLL_LIM)) roll_deg <= -ROLL_LIM;
      else roll_deg <= ra[15:0];
      if (pa > RND_W'(PITCH_LIM)) pitch_deg <= PITCH_LIM;
      else if (pa < -RND_W'(PITCH_LIM)) pitch_deg <= -PITCH_LIM;
      else pitch_deg <= pa[14:0];
      if (ya > RND_W'(ROLL_LIM)) yaw_deg <= ROLL_LIM;
      else if (ya < -RND_W'(ROLL_LIM)) yaw_deg <= -ROLL_LIM;
      else yaw_deg <= ya[15:0];
    end
  end

  `ASSERT_RST_PROP(a_reset_clears, rst |=> !out_valid)
  `ASSERT_PROP(a_lanes_aligned, (rv == pv) && (rv == yv))
  `ASSERT_PROP(a_roll_range, out_valid |-> (roll_deg <= ROLL_LIM) && (roll_deg >= -ROLL_LIM))
  `ASSERT_PROP(a_yaw_range, out_valid |-> (yaw_deg <= ROLL_LIM) && (yaw_deg >= -ROLL_LIM))
  `ASSERT_PROP(a_pitch_range, out_valid |-> (pitch_deg <= PITCH_LIM) && (pitch_deg >= -PITCH_LIM))

endmodule

// ----- sim/tb_quaternion_to_euler_angles_unit.sv -----
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles_unit
  import qte_pkg::*;
();

  localparam int STAGES = 16;
  localparam int N_RANDOM = 1800;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  // fixed-point cordic atan2, degrees * 2^20
  function automatic longint cordic_angle(longint yi, longint xi);
    longint x, y, ang, dx, dy, t;
    x = xi;
    y = yi;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 64'(DEG90);
      end else begin
        t = x; x = -y; y = t; ang = -64'(DEG90);
      end
    end
    for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += 64'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; ang -= 64'(ATAN_TAB[i]);
      end
    end
    return ang;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint to_degrees(longint ang, longint lim);
    longint v;
    v = (ang + 4096) >>> 13;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic angles_t euler_of(longint x, longint y, longint z, longint w);
    longint one, t0, t1, t2, t3, t4, c;
    angles_t a;
    one = 64'sd1 <<< 28;
    t0 = 2 * (w * x + y * z);
    t1 = one - 2 * (x * x + y * y);
    t2 = 2 * (w * y - z * x);
    if (t2 > one) t2 = one;
    if (t2 < -one) t2 = -one;
    t3 = 2 * (w * z + x * y);
    t4 = one - 2 * (y * y + z * z);
    c = floor_sqrt((64'd1 << 56) - 64'(t2 * t2));
    a.roll = 16'(to_degrees(cordic_angle(t0, t1), 23040));
    a.pitch = 15'(to_degrees(cordic_angle(t2, c), 11520));
    a.yaw = 16'(to_degrees(cordic_angle(t3, t4), 23040));
    return a;
  endfunction

  class angle_scoreboard;
    angles_t pending[$];
    int errors = 0;
    int checked = 0;

    function void note_quat(logic signed [15:0] x, y, z, w);
      pending.push_back(euler_of(x, y, z, w));
    endfunction

    function void check_angles(logic signed [15:0] r, logic signed [14:0] p,
                               logic signed [15:0] yw);
      angles_t e;
      if (pending.size() == 0) begin
        $error("unexpected result roll=%0d pitch=%0d yaw=%0d", r, p, yw);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r !== e.roll) begin
        $error("roll_deg expected %0d actual %0d", e.roll, r); errors++;
      end
      if (p !== e.pitch) begin
        $error("pitch_deg expected %0d actual %0d", e.pitch, p); errors++;
      end
      if (yw !== e.yaw) begin
        $error("yaw_deg expected %0d actual %0d", e.yaw, yw); errors++;
      end
    endfunction
  endclass

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w, roll_deg, yaw_deg;
  logic signed [14:0] pitch_deg;
  angle_scoreboard sb;
  bit calm;
  int cycles;

  quaternion_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_quaternion_to_euler_angles_unit failed");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, checks on accepted transactions
  initial begin
    int burst;
    out_stall = 0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_angles(roll_deg, pitch_deg, yaw_deg);
      if (burst > 0) burst--;
      else if (!calm && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 6);
      out_stall <= (burst > 0);
    end
  end

  task automatic send_quat(logic signed [15:0] x, y, z, w);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    quat_x <= x; quat_y <= y; quat_z <= z; quat_w <= w;
    do @(posedge clk); while (in_stall);
    sb.note_quat(x, y, z, w);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  initial begin
    logic signed [15:0] v[4];
    real n;
    sb = new();
    calm = 0;
    rst = 1; in_valid = 0; quat_x = 0; quat_y = 0; quat_z = 0; quat_w = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed: identity, axes, zero pair, extremes, pitch saturation, gimbal lock
    send_quat(0, 0, 0, 16384);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, -16384);
    send_quat(0, 0, 0, 0);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(11585, 0, 0, 11585);
    send_quat(0, 11585, 0, 11585);
    send_quat(0, -11585, 0, 11585);
    send_quat(0, 0, 11585, 11585);
    send_quat(8192, 8192, -8192, 8192);
    send_quat(-8192, 8192, 8192, 8192);
    send_quat(0, 32767, 0, 32767);
    send_quat(32767, 0, 32767, 0);
    send_quat(0, 0, -11585, -11585);
    send_quat(-1, 1, -1, 1);
    // random: mostly unit quaternions, some raw codes
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 200) calm = 1;
      if ($urandom_range(0, 4) == 0) begin
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end else begin
        n = 0;
        foreach (v[i]) begin
          v[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
          n += real'(v[i]) * real'(v[i]);
        end
        if (n < 1.0) n = 1.0;
        n = $sqrt(n);
        send_quat(16'($rtoi(v[0] * 16384.0 / n)), 16'($rtoi(v[1] * 16384.0 / n)),
                  16'($rtoi(v[2] * 16384.0 / n)), 16'($rtoi(v[3] * 16384.0 / n)));
      end
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (STAGES + 60) @(posedge clk);
    $display("checked %0d angle triples from directed and random quaternions",
             sb.checked);
    if (sb.errors == 0)
      $display("tb_quaternion_to_euler_angles_unit passed");
    else
      $display("tb_quaternion_to_euler_angles_unit failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/qte_pkg.sv
rtl/core/qte_terms.sv
rtl/core/qte_isqrt.sv
rtl/core/qte_atan2.sv
rtl/core/quaternion_to_euler_angles_unit.sv
sim/tb_quaternion_to_euler_angles_unit.sv
